@@ rtl/core/afcrb_pkg.sv @@
// afcrb_pkg: shared types, result codes and the frame checksum function
// for the adc frame check ring buffer; no dependencies
`default_nettype none

package afcrb_pkg;

  // field widths fixed by the frame format
  localparam int STATUS_W = 8;
  localparam int WORD_W   = 32;
  localparam int CHECK_W  = 8;
  localparam int COUNT_W  = 7;
  localparam int KIND_W   = 3;
  localparam int TOTAL_W  = 32;

  // checksum offset added to the byte sum
  localparam logic [CHECK_W-1:0] CHECK_OFFSET = 8'h9B;

  // reset value of the expected status register
  localparam logic [STATUS_W-1:0] STATUS_RESET = 8'h60;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_STORED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OVERRUN    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BAD_STATUS = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BAD_CHECK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WORD       = 3'd4;
  localparam logic [KIND_W-1:0] KIND_EMPTY      = 3'd5;

  // commands from the controller to the datapath
  typedef struct packed {
    logic push_go;   // push frame accepted this cycle
    logic read_go;   // read request accepted this cycle
    logic word_go;   // emit one burst word this cycle
  } afcrb_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic ring_empty;  // read pointer equals write pointer
    logic burst_last;  // one burst word left
  } afcrb_stat_t;

  // sum of the four sample bytes plus the offset, mod 256
  function automatic logic [CHECK_W-1:0] frame_sum(input logic [WORD_W-1:0] w);
    logic [CHECK_W+1:0] s;
    s = {2'b00, w[31:24]} + {2'b00, w[23:16]} + {2'b00, w[15:8]}
      + {2'b00, w[7:0]} + {2'b00, CHECK_OFFSET};
    return s[CHECK_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/afcrb_ctrl.sv @@
// afcrb_ctrl: controller state machine, handles the input handshake and
// sequences read bursts; depends on afcrb_pkg
`default_nettype none

module afcrb_ctrl
  import afcrb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_operation,
  output logic             in_stall,
  input  wire afcrb_stat_t stat,
  output afcrb_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_BURST = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  // a transaction is taken only in idle with room at the output
  assign take     = in_valid && (state_r == ST_IDLE) && stat.out_free;
  assign in_stall = !((state_r == ST_IDLE) && stat.out_free);

  // command decode and next state
  always_comb begin
    state_nxt   = state_r;
    cmd.push_go = 1'b0;
    cmd.read_go = 1'b0;
    cmd.word_go = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (in_operation == OP_PUSH) begin
            cmd.push_go = 1'b1;
          end else begin
            cmd.read_go = 1'b1;
            if (!stat.ring_empty) begin
              state_nxt = ST_BURST;
            end
          end
        end
      end
      ST_BURST: begin
        if (stat.out_free) begin
          cmd.word_go = 1'b1;
          if (stat.burst_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/afcrb_dp.sv @@
// afcrb_dp: datapath with the sample store, ring pointers, error counters,
// frame checks and the output register; depends on afcrb_pkg
`default_nettype none

module afcrb_dp
  import afcrb_pkg::*;
#(
  parameter int RING_DEPTH = 256,
  parameter int MAX_BURST  = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [STATUS_W-1:0] cfg_wr_data,
  input  wire logic [STATUS_W-1:0] in_status_byte,
  input  wire logic [WORD_W-1:0]   in_sample_word,
  input  wire logic [CHECK_W-1:0]  in_check_byte,
  input  wire logic [COUNT_W-1:0]  in_max_count,
  input  wire afcrb_cmd_t          cmd,
  output afcrb_stat_t              stat,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [KIND_W-1:0]        out_result_kind,
  output logic [WORD_W-1:0]        out_data_word,
  output logic                     out_last,
  output logic [TOTAL_W-1:0]       out_overrun_total,
  output logic [TOTAL_W-1:0]       out_checksum_error_total,
  output logic [TOTAL_W-1:0]       out_status_error_total
);

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int AV_W  = PTR_W + 1;
  localparam int CNT_W = $clog2(MAX_BURST + 1);
  localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(RING_DEPTH - 1);
  localparam logic [AV_W-1:0]    DEPTH_AV  = AV_W'(RING_DEPTH);
  localparam logic [COUNT_W-1:0] BURST_MC  = COUNT_W'(MAX_BURST);
  localparam logic [CNT_W-1:0]   BURST_CNT = CNT_W'(MAX_BURST);
  localparam logic [CNT_W-1:0]   ONE_CNT   = CNT_W'(1);

  logic [WORD_W-1:0] mem [RING_DEPTH];
  logic [WORD_W-1:0] rdata_r;

  logic [STATUS_W-1:0] exp_status_r;
  logic [PTR_W-1:0]    wp_r, wp_nxt, rp_r, rp_nxt, wp_inc, rp_inc;
  logic [CNT_W-1:0]    remain_r, remain_nxt;
  logic [TOTAL_W-1:0]  ovr_r, ovr_nxt, cks_r, cks_nxt, sts_r, sts_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [WORD_W-1:0]   data_r, data_nxt;
  logic                last_r, last_nxt;

  logic                status_ok, check_ok, ring_full, ring_empty, mem_we;
  logic [AV_W-1:0]     avail;
  logic [CNT_W-1:0]    want, burst_n;

  // pointer increments with wrap at the physical end
  assign wp_inc = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;

  // frame checks and ring occupancy
  assign status_ok  = (in_status_byte == exp_status_r);
  assign check_ok   = (frame_sum(in_sample_word) == in_check_byte);
  assign ring_full  = (wp_inc == rp_r);
  assign ring_empty = (wp_r == rp_r);

  // words up to the write pointer or up to the physical end
  assign avail = (rp_r < wp_r) ? ({1'b0, wp_r} - {1'b0, rp_r})
                               : (DEPTH_AV - {1'b0, rp_r});

  // clamp the requested count to 1..MAX_BURST
  always_comb begin
    if (in_max_count == '0) begin
      want = ONE_CNT;
    end else if (in_max_count > BURST_MC) begin
      want = BURST_CNT;
    end else begin
      want = CNT_W'(in_max_count);
    end
  end

  // burst length is the smaller of available and requested
  always_comb begin
    if ((AV_W >= CNT_W) ? (avail < AV_W'(want)) : (CNT_W'(avail) < want)) begin
      burst_n = CNT_W'(avail);
    end else begin
      burst_n = want;
    end
  end

  assign stat.out_free   = !out_valid_r || !out_stall;
  assign stat.ring_empty = ring_empty;
  assign stat.burst_last = (remain_r == ONE_CNT);

  // push, read and burst updates
  always_comb begin
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    remain_nxt    = remain_r;
    ovr_nxt       = ovr_r;
    cks_nxt       = cks_r;
    sts_nxt       = sts_r;
    mem_we        = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    if (cmd.push_go) begin
      out_valid_nxt = 1'b1;
      data_nxt      = '0;
      last_nxt      = 1'b1;
      if (!status_ok) begin
        sts_nxt  = sts_r + 1'b1;
        kind_nxt = KIND_BAD_STATUS;
      end else if (!check_ok) begin
        cks_nxt  = cks_r + 1'b1;
        kind_nxt = KIND_BAD_CHECK;
      end else if (ring_full) begin
        ovr_nxt  = ovr_r + 1'b1;
        kind_nxt = KIND_OVERRUN;
      end else begin
        mem_we   = 1'b1;
        wp_nxt   = wp_inc;
        kind_nxt = KIND_STORED;
      end
    end else if (cmd.read_go) begin
      if (ring_empty) begin
        out_valid_nxt = 1'b1;
        kind_nxt      = KIND_EMPTY;
        data_nxt      = '0;
        last_nxt      = 1'b1;
      end else begin
        remain_nxt = burst_n;
      end
    end else if (cmd.word_go) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_WORD;
      data_nxt      = rdata_r;
      last_nxt      = (remain_r == ONE_CNT);
      remain_nxt    = remain_r - 1'b1;
      rp_nxt        = rp_inc;
    end
  end

  // sample store, read address follows the next read pointer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= in_sample_word;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rp_nxt];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_status_r <= STATUS_RESET;
      wp_r         <= '0;
      rp_r         <= '0;
      remain_r     <= '0;
      ovr_r        <= '0;
      cks_r        <= '0;
      sts_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        exp_status_r <= cfg_wr_data;
      end
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      remain_r    <= remain_nxt;
      ovr_r       <= ovr_nxt;
      cks_r       <= cks_nxt;
      sts_r       <= sts_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  assign out_valid                = out_valid_r;
  assign out_result_kind          = kind_r;
  assign out_data_word            = data_r;
  assign out_last                 = last_r;
  assign out_overrun_total        = ovr_r;
  assign out_checksum_error_total = cks_r;
  assign out_status_error_total   = sts_r;

endmodule

`default_nettype wire

@@ rtl/core/adc_frame_check_ring_buffer.sv @@
// adc_frame_check_ring_buffer: top level, joins the controller and the
// datapath; depends on afcrb_pkg, afcrb_ctrl and afcrb_dp
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  operation, status, sample, check, count
//   out_     output     out_valid / out_stall kind, word, last, three totals
//   cfg_     input      cfg_wr_en            expected status byte
//
// a push transaction's result is registered at the accept edge
// a read transaction is accepted in idle, then its words leave the
// registered store port one per cycle while out_stall is low
// in_stall is high during a burst and while a waiting result sees out_stall
// synchronous active-low reset clears pointers and counters, presets status register
`default_nettype none

module adc_frame_check_ring_buffer
  import afcrb_pkg::*;
#(
  parameter int RING_DEPTH = 256,
  parameter int MAX_BURST  = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [STATUS_W-1:0] cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_operation,
  input  wire logic [STATUS_W-1:0] in_status_byte,
  input  wire logic [WORD_W-1:0]   in_sample_word,
  input  wire logic [CHECK_W-1:0]  in_check_byte,
  input  wire logic [COUNT_W-1:0]  in_max_count,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [KIND_W-1:0]        out_result_kind,
  output logic [WORD_W-1:0]        out_data_word,
  output logic                     out_last,
  output logic [TOTAL_W-1:0]       out_overrun_total,
  output logic [TOTAL_W-1:0]       out_checksum_error_total,
  output logic [TOTAL_W-1:0]       out_status_error_total
);

  afcrb_cmd_t  cmd;
  afcrb_stat_t stat;

  // controller
  afcrb_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  // datapath
  afcrb_dp #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_BURST  (MAX_BURST)
  ) u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_wr_en                (cfg_wr_en),
    .cfg_wr_data              (cfg_wr_data),
    .in_status_byte           (in_status_byte),
    .in_sample_word           (in_sample_word),
    .in_check_byte            (in_check_byte),
    .in_max_count             (in_max_count),
    .cmd                      (cmd),
    .stat                     (stat),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_result_kind          (out_result_kind),
    .out_data_word            (out_data_word),
    .out_last                 (out_last),
    .out_overrun_total        (out_overrun_total),
    .out_checksum_error_total (out_checksum_error_total),
    .out_status_error_total   (out_status_error_total)
  );

endmodule

`default_nettype wire
